/* rtl/tent_blur_7x7_rgba_unit_defines.svh */
// Assertion helpers shared by the tent blur RTL.
// Each use expands to one labelled concurrent assertion on clk, off while rst_n is low.
`ifndef TENT_BLUR_7X7_RGBA_UNIT_DEFINES_SVH
`define TENT_BLUR_7X7_RGBA_UNIT_DEFINES_SVH

// Same-cycle implication
`define TBLUR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tent blur check failed");

// Next-cycle implication
`define TBLUR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tent blur check failed");

`endif

/* rtl/tblur_pkg.sv */
package tblur_pkg;

  localparam int PIX_W      = 32;
  localparam int TAPS       = 7;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CMDQ_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Request kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Row slot of the first output row relative to input row zero (-3 mod 7)
  localparam logic [2:0] ROT_INIT = 3'd4;

  // Tent weights 1,2,3,4,3,2,1
  localparam logic [2:0] TENT_WGT [TAPS] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd3, 3'd2, 3'd1};

  typedef struct packed {
    logic              kind;
    logic [PIX_W-1:0]  pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]  blurred;
    logic              frame_last;
  } out_item_t;

  // Work handed from the front to the back
  typedef struct packed {
    logic              bypass;  // pass pixel straight out
    logic              adv;     // read a column, shift the window
    logic              emit;    // produces a result
    logic              last;    // final result of the frame
    logic              wr;      // store pixel into the row slot
    logic [2:0]        wslot;   // row slot written
    logic [2:0]        rot;     // slot of the row the read column serves
    logic [1:0]        cl;      // distance to left edge, 3 = none near
    logic [1:0]        cr;      // distance to right edge
    logic [1:0]        rt;      // distance to top edge
    logic [1:0]        rb;      // distance to bottom edge
    logic [PIX_W-1:0]  pixel;
  } cmd_t;

  // Reduce a small sum modulo 7
  function automatic logic [2:0] mod7(input logic [4:0] x);
    logic [4:0] s;
    s = x;
    if (s >= 5'd7) s = s - 5'd7;
    if (s >= 5'd7) s = s - 5'd7;
    return s[2:0];
  endfunction

  // Per-channel tent over seven pixels, truncated to 8 bits
  function automatic logic [PIX_W-1:0] tent7(input logic [TAPS-1:0][PIX_W-1:0] v);
    logic [11:0]      acc;
    logic [PIX_W-1:0] res;
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      acc = '0;
      for (int t = 0; t < TAPS; t++) begin
        acc = acc + 12'(TENT_WGT[t]) * 12'(v[t][ch*8 +: 8]);
      end
      res[ch*8 +: 8] = acc[11:4];
    end
    return res;
  endfunction

endpackage

/* rtl/tblur_ram.sv */
module tblur_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write, one registered read; a read at the written address sees old data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tblur_cmdq.sv */
`include "tent_blur_7x7_rgba_unit_defines.svh"

module tblur_cmdq #(
  parameter int W     = 64,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         valid,
  output logic         full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  store_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign valid   = count_r != '0;
  assign full    = count_r == NW'(DEPTH);
  assign dout    = store_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + NW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wptr_r] <= din;
    end
  end

  `TBLUR_ASSERT_IMPL(a_no_push_when_full, push, !full)
  `TBLUR_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= NW'(DEPTH))

endmodule

/* rtl/tblur_front.sv */
`include "tent_blur_7x7_rgba_unit_defines.svh"

module tblur_front #(
  parameter int MAX_WIDTH = 2048,
  localparam int CB = $clog2(MAX_WIDTH)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  acc,
  input  tblur_pkg::in_item_t                   item,
  input  logic                                  cfg_we,
  input  logic [tblur_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tblur_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                  push,
  output tblur_pkg::cmd_t                       cmd,
  output logic [CB-1:0]                         rd_col
);

  localparam int AW = $clog2(MAX_WIDTH + 1);
  localparam int HW = tblur_pkg::FH_W;

  logic [tblur_pkg::FW_W-1:0] fw_r, fw_nxt;
  logic [HW-1:0]              fh_r, fh_nxt;
  logic [CB-1:0]              in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [CB-1:0]              rd_col_r, rd_col_nxt;
  logic [HW-1:0]              in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [2:0]                 in_rmod_r, in_rmod_nxt, rot_r, rot_nxt;

  logic [AW-1:0] aw, in_col_inc, out_col_inc, rd_col_inc, dr;
  logic [HW-1:0] db;
  logic          in_wrap, out_wrap, rd_wrap, byp, started, last_out;

  assign rd_col = rd_col_r;

  always_comb begin
    // Active width, held to the row store size
    if (32'(fw_r) > MAX_WIDTH) aw = AW'(MAX_WIDTH);
    else aw = AW'(fw_r);
    byp = (aw <= AW'(7)) || (fh_r <= HW'(7));

    in_col_inc  = AW'(in_col_r) + AW'(1);
    out_col_inc = AW'(out_col_r) + AW'(1);
    rd_col_inc  = AW'(rd_col_r) + AW'(1);
    in_wrap     = in_col_inc >= aw;
    out_wrap    = out_col_inc >= aw;
    rd_wrap     = rd_col_inc >= aw;

    // Results start three rows and three columns behind the input
    started  = (in_row_r > HW'(3)) || ((in_row_r == HW'(3)) && (in_col_r >= CB'(3)));
    last_out = (out_row_r == fh_r - HW'(1)) && (out_col_inc == aw);

    dr = aw - AW'(1) - AW'(out_col_r);
    db = fh_r - HW'(1) - out_row_r;

    fw_nxt      = fw_r;
    fh_nxt      = fh_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    rd_col_nxt  = rd_col_r;
    in_rmod_nxt = in_rmod_r;
    rot_nxt     = rot_r;

    push       = 1'b0;
    cmd        = '0;
    cmd.pixel  = item.pixel;
    cmd.wslot  = in_rmod_r;
    cmd.rot    = rot_r;
    cmd.cl     = (out_col_r < CB'(3)) ? out_col_r[1:0] : 2'd3;
    cmd.cr     = (dr < AW'(3)) ? dr[1:0] : 2'd3;
    cmd.rt     = (out_row_r < HW'(3)) ? out_row_r[1:0] : 2'd3;
    cmd.rb     = (db < HW'(3)) ? db[1:0] : 2'd3;

    if (acc) begin
      if (byp) begin
        // Small frame: pass straight through
        if (item.kind == tblur_pkg::KIND_PIXEL) begin
          push       = 1'b1;
          cmd.bypass = 1'b1;
          cmd.emit   = 1'b1;
          if ((aw != '0) && (fh_r != '0)) begin
            cmd.last = (in_col_inc == aw) && (in_row_r == fh_r - HW'(1));
            if (in_wrap) begin
              in_col_nxt = '0;
              if (({1'b0, in_row_r} + 17'd1) >= {1'b0, fh_r}) in_row_nxt = '0;
              else in_row_nxt = in_row_r + HW'(1);
            end else begin
              in_col_nxt = CB'(in_col_inc);
            end
          end
        end
      end else if (item.kind == tblur_pkg::KIND_PIXEL) begin
        // Pixel of the frame: store it, read a column, maybe emit
        if (in_row_r < fh_r) begin
          push     = 1'b1;
          cmd.adv  = 1'b1;
          cmd.wr   = 1'b1;
          cmd.emit = started;
          if (in_wrap) begin
            in_col_nxt  = '0;
            in_row_nxt  = in_row_r + HW'(1);
            in_rmod_nxt = (in_rmod_r == 3'd6) ? 3'd0 : in_rmod_r + 3'd1;
          end else begin
            in_col_nxt = CB'(in_col_inc);
          end
          rd_col_nxt = rd_wrap ? '0 : CB'(rd_col_inc);
          if (rd_wrap) rot_nxt = (rot_r == 3'd6) ? 3'd0 : rot_r + 3'd1;
          if (started) begin
            out_col_nxt = out_wrap ? '0 : CB'(out_col_inc);
            if (out_wrap) out_row_nxt = out_row_r + HW'(1);
          end
        end
      end else if ((in_row_r >= fh_r) && (out_row_r < fh_r)) begin
        // Drain request releasing one pending result
        push     = 1'b1;
        cmd.adv  = 1'b1;
        cmd.emit = 1'b1;
        cmd.last = last_out;
        if (last_out) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          rd_col_nxt  = '0;
          in_rmod_nxt = '0;
          rot_nxt     = tblur_pkg::ROT_INIT;
        end else begin
          out_col_nxt = out_wrap ? '0 : CB'(out_col_inc);
          if (out_wrap) out_row_nxt = out_row_r + HW'(1);
          rd_col_nxt = rd_wrap ? '0 : CB'(rd_col_inc);
          if (rd_wrap) rot_nxt = (rot_r == 3'd6) ? 3'd0 : rot_r + 3'd1;
        end
      end
    end

    // Register write: new geometry, frame restarts
    if (cfg_we) begin
      case (cfg_index)
        tblur_pkg::CFG_FRAME_WIDTH: begin
          fw_nxt      = cfg_data[tblur_pkg::FW_W-1:0];
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          rd_col_nxt  = '0;
          in_rmod_nxt = '0;
          rot_nxt     = tblur_pkg::ROT_INIT;
        end
        tblur_pkg::CFG_FRAME_HEIGHT: begin
          fh_nxt      = cfg_data;
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          rd_col_nxt  = '0;
          in_rmod_nxt = '0;
          rot_nxt     = tblur_pkg::ROT_INIT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= 12'd64;
      fh_r      <= 16'd64;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      rd_col_r  <= '0;
      in_rmod_r <= '0;
      rot_r     <= tblur_pkg::ROT_INIT;
    end else begin
      fw_r      <= fw_nxt;
      fh_r      <= fh_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      rd_col_r  <= rd_col_nxt;
      in_rmod_r <= in_rmod_nxt;
      rot_r     <= rot_nxt;
    end
  end

  `TBLUR_ASSERT_IMPL(a_last_emits, push && cmd.last, cmd.emit)
  `TBLUR_ASSERT_NEXT(a_frame_restart, push && cmd.last && !cmd.bypass,
                     (in_row_r == '0) && (out_row_r == '0) && (rd_col_r == '0))
  `TBLUR_ASSERT_IMPL(a_out_behind_in, 1'b1, out_row_r <= in_row_r)

endmodule

/* rtl/tblur_back.sv */
module tblur_back #(
  parameter int MAX_WIDTH = 2048,
  localparam int CB = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  tblur_pkg::cmd_t      q_cmd,
  input  logic [CB-1:0]        q_col,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output tblur_pkg::out_item_t out_item
);

  localparam int T  = tblur_pkg::TAPS;
  localparam int PW = tblur_pkg::PIX_W;

  logic [PW-1:0]             rd_data [T];
  logic [T-1:0][PW-1:0]      col_new, row_col, h_row;
  logic [T-1:0][T-1:0][PW-1:0] win_r;   // [column age][row]
  logic [T-1:0][PW-1:0]      s3_h_r;
  logic [PW-1:0]             v_res;
  logic                      en;
  logic                      s1_v_r, s2_v_r, s3_v_r, out_v_r;
  tblur_pkg::cmd_t           s1_cmd_r, s2_cmd_r, s3_cmd_r;
  tblur_pkg::out_item_t      out_item_r;

  // Whole back end moves when the result register can take a new value
  assign en        = !out_v_r || out_pop;
  assign q_pop     = en && q_valid;
  assign out_empty = !out_v_r;
  assign out_item  = out_item_r;

  // Seven row slots, one column read per advancing request
  for (genvar s = 0; s < T; s++) begin : g_slot
    tblur_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (q_pop && q_cmd.wr && (q_cmd.wslot == 3'(s))),
      .wr_addr (q_col),
      .wr_data (q_cmd.pixel),
      .rd_en   (q_pop && q_cmd.adv),
      .rd_addr (q_col),
      .rd_data (rd_data[s])
    );
  end

  // Forward the pixel just written, then rotate slots into row order
  always_comb begin
    for (int s = 0; s < T; s++) begin
      col_new[s] = (s1_cmd_r.wr && (s1_cmd_r.wslot == 3'(s))) ? s1_cmd_r.pixel : rd_data[s];
    end
    for (int j = 0; j < T; j++) begin
      row_col[j] = col_new[0];
      for (int s = 0; s < T; s++) begin
        if (tblur_pkg::mod7(5'(s1_cmd_r.rot) + 5'(j) + 5'd4) == 3'(s)) row_col[j] = col_new[s];
      end
    end
  end

  // Horizontal pass with edge replication
  always_comb begin
    logic [T-1:0][PW-1:0] p;
    h_row = '0;
    for (int j = 0; j < T; j++) begin
      for (int t = 0; t < T; t++) p[t] = win_r[T-1-t][j];
      for (int t = 2; t >= 0; t--) begin
        if (t < 3 - int'(s2_cmd_r.cl)) p[t] = p[t+1];
      end
      for (int t = 4; t < T; t++) begin
        if (t > 3 + int'(s2_cmd_r.cr)) p[t] = p[t-1];
      end
      h_row[j] = tblur_pkg::tent7(p);
    end
  end

  // Vertical pass with edge replication
  always_comb begin
    logic [T-1:0][PW-1:0] q;
    q = s3_h_r;
    for (int t = 2; t >= 0; t--) begin
      if (t < 3 - int'(s3_cmd_r.rt)) q[t] = q[t+1];
    end
    for (int t = 4; t < T; t++) begin
      if (t > 3 + int'(s3_cmd_r.rb)) q[t] = q[t-1];
    end
    v_res = tblur_pkg::tent7(q);
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= q_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r && s3_cmd_r.emit;
    end
  end

  // Stage payload and column window
  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r <= q_cmd;
      s2_cmd_r <= s1_cmd_r;
      s3_cmd_r <= s2_cmd_r;
      s3_h_r   <= h_row;
      if (s1_v_r && s1_cmd_r.adv) begin
        win_r[0] <= row_col;
        for (int k = 1; k < T; k++) win_r[k] <= win_r[k-1];
      end
      out_item_r.blurred    <= s3_cmd_r.bypass ? s3_cmd_r.pixel : v_res;
      out_item_r.frame_last <= s3_cmd_r.last;
    end
  end

endmodule

/* rtl/tent_blur_7x7_rgba_unit.sv */
// Separable 7x7 tent blur (weights 1,2,3,4,3,2,1 per axis, each pass /16 truncated) on
// raster-order 32-bit four-channel pixels with edges clamped. One request is taken per
// clock while in_full is low. Outside pass-through each pixel request writes one pixel
// and each request reads one column across the seven row RAMs (one write and one read
// port each). A popped request passes stages s1, s2, s3 and the result register. A
// frame's results lag the input by 3*width+3 pixels; after the last pixel, send
// 3*width+3 drain requests to flush the tail, the final one flagged frame_last. With
// width or height of 7 or less pixels pass through unchanged and drains are dropped.
// Row RAM contents are not cleared after reset, so no start-up pass is needed. Write
// the registers only while the block is idle; a write restarts the frame.
module tent_blur_7x7_rgba_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  tblur_pkg::in_item_t                   in_item,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output tblur_pkg::out_item_t                  out_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tblur_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tblur_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int CW = $bits(tblur_pkg::cmd_t);
  localparam int QW = CB + CW;

  logic            acc, f_push, q_full, q_valid, q_pop;
  tblur_pkg::cmd_t f_cmd, q_cmd;
  logic [CB-1:0]   f_col, q_col;
  logic [QW-1:0]   q_dout;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign acc       = in_push && !q_full;
  assign q_cmd     = tblur_pkg::cmd_t'(q_dout[CW-1:0]);
  assign q_col     = q_dout[QW-1 -: CB];

  tblur_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (in_item),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (f_push),
    .cmd       (f_cmd),
    .rd_col    (f_col)
  );

  tblur_cmdq #(
    .W     (QW),
    .DEPTH (tblur_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   ({f_col, f_cmd}),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid),
    .full  (q_full)
  );

  tblur_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_col     (q_col),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
